[rtl/sobel_edge_magnitude_rgb_macros.svh]
// Assertion macros shared by the Sobel edge magnitude RTL.
// No dependencies; included by files that assert.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication outside reset.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sem_pkg.sv]
// Package for the Sobel edge magnitude block: types, constants, state encoding.
// No dependencies.
`timescale 1ns / 1ps
package sem_pkg;
  localparam int unsigned PixW = 24;
  localparam int unsigned ChW  = 8;
  localparam int unsigned SumW = 17;
  localparam logic [7:0]  MagMax = 8'd255;
  localparam logic        CmdPixel = 1'b0;
  localparam logic        CmdFlush = 1'b1;
  localparam logic        CfgWidth  = 1'b0;
  localparam logic        CfgHeight = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StRead, StGrad, StSqrt, StOut
  } state_e;

  typedef struct packed {
    logic store;
    logic read;
    logic grad;
    logic sqrt_start;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic sqrt_done;
  } stat_t;
endpackage

[rtl/sem_ctrl.sv]
// Controller state machine of the Sobel edge magnitude block.
// Depends on sem_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  sem_pkg::stat_t stat_i,
  output sem_pkg::cmd_t  cmd_o
);
  import sem_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StRead;
      StRead: state_d = stat_i.ready ? StGrad : StIdle;
      StGrad: state_d = StSqrt;
      StSqrt: if (stat_i.sqrt_done) state_d = StOut;
      StOut:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.store = in_valid_i;
      end
      StRead: cmd_o.read = stat_i.ready;
      StGrad: begin
        cmd_o.grad = 1'b1;
        cmd_o.sqrt_start = 1'b1;
      end
      StOut: begin
        out_valid_o = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: ;
    endcase
  end

  `SEM_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "accept during output")
  `SEM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o,
    "output dropped")
  `SEM_ASSERT_NEXT(a_grad, clk_i, rst_ni, cmd_o.grad, state_q == StSqrt, "grad not followed")
endmodule

[rtl/sem_datapath.sv]
// Datapath of the Sobel edge magnitude block: pixel ring, counters, gradients, root.
// Depends on sem_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_macros.svh"
module sem_datapath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sem_pkg::cmd_t  cmd_i,
  output sem_pkg::stat_t stat_o,
  input  logic           command_i,
  input  logic [23:0]    pixel_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [12:0]    cfg_data_i,
  output logic [23:0]    edge_o,
  output logic           last_o
);
  import sem_pkg::*;
  localparam int unsigned Ring = 2 * MAX_WIDTH + 4;
  localparam int unsigned RW = $clog2(Ring);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = $clog2(Ring + 1);
  localparam int unsigned AW = CW + HW + 1;

  logic [10:0] wreg_q;
  logic [12:0] hreg_q;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [PixW-1:0] ring_q [Ring];
  logic [RW-1:0] pos_q;
  logic [PW-1:0] pend_q;
  logic [HW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [3:0]    tap_q;
  logic [PixW-1:0] rd_q;
  logic [3:0]    tap_d1_q;
  logic          tap_v_q;
  logic signed [SumW-1:0] gx_q [3];
  logic signed [SumW-1:0] gy_q [3];
  logic [AW-1:0] remain_q;
  logic          pend_ok;
  logic [RW-1:0] wr_addr, rd_addr;
  logic          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= 11'd1024;
      hreg_q <= 13'd1024;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgWidth) wreg_q <= cfg_data_i[10:0];
      else hreg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (wreg_q == '0) w_eff = CW'(1);
    else if (32'(wreg_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(wreg_q);
    if (hreg_q == '0) h_eff = HW'(1);
    else if (32'(hreg_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(hreg_q);
  end

  // pixels remaining after current output, product formed in a register
  always_ff @(posedge clk_i) begin
    remain_q <= AW'((AW'(h_eff) - AW'(1) - AW'(row_q)) * AW'(w_eff))
              + AW'(w_eff) - AW'(1) - AW'(col_q);
  end

  always_comb begin
    logic [AW:0] th;
    th = (AW+1)'(w_eff) + (AW+1)'(1);
    if (remain_q[AW-1]) th = '0;
    else if ((AW+1)'(remain_q) < th) th = (AW+1)'(remain_q);
    pend_ok = (AW+1)'(pend_q) > th;
  end
  assign stat_o.ready = pend_ok;

  function automatic logic [RW-1:0] wrap_add(logic [RW-1:0] a, logic [RW:0] b);
    logic [RW+1:0] s;
    s = (RW+2)'(a) + (RW+2)'(b);
    if (s >= (RW+2)'(Ring)) s = s - (RW+2)'(Ring);
    return RW'(s);
  endfunction

  assign wr_addr = wrap_add(pos_q, (RW+1)'(pend_q));

  logic signed [2:0] ta, tb;
  logic [RW:0] off;
  logic tap_in;
  always_comb begin
    logic signed [HW+1:0] rr;
    logic signed [CW+1:0] cc;
    if (tap_q < 4'd3) ta = -3'sd1;
    else if (tap_q < 4'd6) ta = 3'sd0;
    else ta = 3'sd1;
    if (tap_q inside {4'd0, 4'd3, 4'd6}) tb = -3'sd1;
    else if (tap_q inside {4'd1, 4'd4, 4'd7}) tb = 3'sd0;
    else tb = 3'sd1;
    off = (RW+1)'(Ring);
    if (ta == -3'sd1) off = off - (RW+1)'(w_eff);
    if (ta == 3'sd1) off = off + (RW+1)'(w_eff);
    off = off + (RW+1)'(signed'(tb));
    if (off >= (RW+1)'(Ring)) off = off - (RW+1)'(Ring);
    if (off >= (RW+1)'(Ring)) off = off - (RW+1)'(Ring);
    rr = (HW+2)'(signed'({1'b0, row_q})) + (HW+2)'(ta);
    cc = (CW+2)'(signed'({1'b0, col_q})) + (CW+2)'(tb);
    tap_in = !rr[HW+1] && (rr < (HW+2)'(signed'({1'b0, h_eff}))) &&
             !cc[CW+1] && (cc < (CW+2)'(signed'({1'b0, w_eff})));
  end
  assign rd_addr = wrap_add(pos_q, off);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && command_i == CmdPixel && 32'(pend_q) < Ring)
      ring_q[wr_addr] <= pixel_i;
    rd_q <= ring_q[rd_addr];
  end

  logic walking_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; pend_q <= '0; row_q <= '0; col_q <= '0;
      tap_q <= '0; walking_q <= 1'b0; tap_v_q <= 1'b0; tap_d1_q <= '0;
    end else begin
      if (cmd_i.store && command_i == CmdPixel && 32'(pend_q) < Ring)
        pend_q <= pend_q + PW'(1);
      if (cmd_i.read) begin walking_q <= 1'b1; tap_q <= '0; end
      else if (walking_q) begin
        tap_q <= tap_q + 4'd1;
        if (tap_q == 4'd8) walking_q <= 1'b0;
      end
      tap_v_q <= walking_q && tap_in;
      tap_d1_q <= tap_q;
      if (cmd_i.advance) begin
        pos_q <= wrap_add(pos_q, (RW+1)'(1));
        pend_q <= pend_q - PW'(1);
        if (col_q + CW'(1) >= w_eff) begin
          col_q <= '0;
          row_q <= (row_q + HW'(1) >= h_eff) ? '0 : row_q + HW'(1);
        end else col_q <= col_q + CW'(1);
      end
    end
  end

  // accumulate taps; the walk drains during the sqrt wait that the grad state starts
  logic acc_clr_q;
  always_ff @(posedge clk_i) begin
    acc_clr_q <= cmd_i.read;
    for (int c = 0; c < 3; c++) begin
      logic signed [SumW-1:0] v, kx, ky;
      v = SumW'(signed'({1'b0, rd_q[16-8*c +: ChW]}));
      case (tap_d1_q)
        4'd0: begin kx = -v;       ky = -v;       end
        4'd1: begin kx = '0;       ky = -(v <<< 1); end
        4'd2: begin kx = v;        ky = -v;       end
        4'd3: begin kx = -(v <<< 1); ky = '0;     end
        4'd5: begin kx = v <<< 1;  ky = '0;       end
        4'd6: begin kx = -v;       ky = v;        end
        4'd7: begin kx = '0;       ky = v <<< 1;  end
        4'd8: begin kx = v;        ky = v;        end
        default: begin kx = '0;    ky = '0;       end
      endcase
      if (tap_v_q) begin
        gx_q[c] <= (acc_clr_q ? '0 : gx_q[c]) + kx;
        gy_q[c] <= (acc_clr_q ? '0 : gy_q[c]) + ky;
      end else if (acc_clr_q) begin
        gx_q[c] <= '0;
        gy_q[c] <= '0;
      end
    end
  end

  // serial root: wait for taps, square, then step n over one channel at a time
  logic [1:0] ch_q;
  logic [4:0] wait_q;
  logic [8:0] n_q;
  logic [31:0] s_q;
  logic busy_q, sq_q;
  logic [7:0] res_q [3];
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; ch_q <= '0; wait_q <= '0; sq_q <= 1'b0;
      n_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.sqrt_start) begin busy_q <= 1'b1; ch_q <= '0; wait_q <= 5'd12; end
      else if (busy_q) begin
        if (wait_q != '0) begin
          wait_q <= wait_q - 5'd1;
          if (wait_q == 5'd1) sq_q <= 1'b1;
        end else if (sq_q) begin
          sq_q <= 1'b0; n_q <= '0;
        end else if (n_q < {1'b0, MagMax} && s_q > 32'(n_q) * 32'(n_q) + 32'(n_q)) begin
          n_q <= n_q + 9'd1;
        end else begin
          if (ch_q == 2'd2) begin busy_q <= 1'b0; done_q <= 1'b1; end
          else begin ch_q <= ch_q + 2'd1; sq_q <= 1'b1; end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_q) s_q <= 32'(gx_q[ch_q] * gx_q[ch_q]) + 32'(gy_q[ch_q] * gy_q[ch_q]);
    if (busy_q && wait_q == '0 && !sq_q &&
        !(n_q < {1'b0, MagMax} && s_q > 32'(n_q) * 32'(n_q) + 32'(n_q)))
      res_q[ch_q] <= n_q[7:0];
    if (cmd_i.sqrt_start) last_q <= (row_q == h_eff - HW'(1)) && (col_q == w_eff - CW'(1));
  end

  assign stat_o.sqrt_done = done_q;
  assign edge_o = {res_q[2], res_q[1], res_q[0]};
  assign last_o = last_q;

  `SEM_ASSERT_IMP(a_adv, clk_i, rst_ni, cmd_i.advance, pend_q != '0, "advance on empty")
  `SEM_ASSERT_IMP(a_col, clk_i, rst_ni, 1'b1, col_q < CW'(MAX_WIDTH), "column out of range")
  `SEM_ASSERT_NEXT(a_pend, clk_i, rst_ni, cmd_i.read, pend_q != '0, "read with no pixel")
endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
// Sobel edge magnitude on an RGB raster stream: top level.
// Instantiates sem_ctrl and sem_datapath; uses sem_pkg.
// Usage:
//   s_axis carries one item per transfer: tuser = command (0 pixel, 1 flush),
//   tdata = red, green, blue from bit 0. m_axis returns edge_red, edge_green,
//   edge_blue in tdata and tlast marks the frame's bottom right output.
//   cfg writes image_width (index 0) and image_height (index 1); the user
//   must write them only while idle, the block itself does not enforce it.
//   Each item takes one input transfer and then the ready check; an item
//   without a result returns to idle after the check. An item with a
//   result walks the 3x3 neighborhood out of the pixel ring, waits for the
//   gradients, then steps a serial root by one per cycle over three
//   channels. No new input is taken before the output transfer; the next
//   input can be taken in the cycle after the output transfer.
//   Outputs lag their pixel by image_width+1 items; flush items drain
//   the rest after the last pixel.
//   Reset clears the counters and the controller; the ring is never cleared.
//   While the receiver stalls the result holds and no input is taken.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // edge_red, edge_green, edge_blue
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);
  import sem_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  logic [23:0] edge_rgb;

  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .stat_i(stat), .cmd_o(cmd)
  );

  sem_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .command_i(s_axis_tuser),
    .pixel_i({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .edge_o(edge_rgb), .last_o(m_axis_tlast)
  );
  assign m_axis_tdata = edge_rgb;
endmodule
